// ===== rtl/core/fvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fire-voltage regulator package
// Payload types, controller command bundle, state encoding, fixed scale
// factors and the filter step shared by the regulator modules.
// ----------------------------------------------------------------------------
package fvr_pkg;

	// Input item: mode selects ADC word (0) or DAC setpoint request (1).
	typedef struct packed {
		logic        mode;
		logic [15:0] adc_word;
	} fvr_in_t;

	// Result item.
	typedef struct packed {
		logic [9:0]  fire_voltage;
		logic [6:0]  motor_voltage;
		logic [9:0]  trim;
		logic [15:0] dac_code;
		logic        dac_valid;
	} fvr_out_t;

	// Controller commands to the datapath, one step per cycle while the output register has room.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic fin;
	} fvr_cmd_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FIN
	} fvr_state_t;

	// ADC channel codes.
	localparam logic [1:0] CH_FIRE  = 2'd1;
	localparam logic [1:0] CH_MOTOR = 2'd2;

	// Register map.
	localparam int unsigned CFG_ADDR_W     = 3;
	localparam logic        CFG_IDX_TARGET = 1'b0;

	// Fixed constants.
	localparam logic [21:0] FIRE_SCALE   = 22'd674;
	localparam logic [21:0] MOTOR_SCALE  = 22'd105;
	localparam logic [13:0] GAIN_BASE    = 14'h1E00;
	localparam logic [9:0]  TRIM_MAX     = 10'h3FF;
	localparam logic [9:0]  TRIM_RESET   = 10'h200;
	localparam logic [8:0]  VOLT_LIMIT   = 9'd500;
	localparam logic [8:0]  TARGET_RESET = 9'd250;
	localparam logic [21:0] DAC_SCALE    = 22'(65535 * 16384 / 500);

	// One first-order filter step: f + (16*s - f + 8) / 16, quotient
	// truncated toward zero.
	function automatic logic signed [16:0] fvr_filt_step(
		input logic signed [16:0] f,
		input logic [11:0]        s
	);
		logic signed [17:0] diff;
		logic signed [17:0] mag;
		logic signed [17:0] quo;
		logic signed [17:0] sum;
		diff = $signed({2'b00, s, 4'b0000}) - $signed({f[16], f}) + 18'sd8;
		mag  = diff[17] ? -diff : diff;
		quo  = mag >>> 4;
		if (diff[17]) begin
			quo = -quo;
		end
		sum = $signed({f[16], f}) + quo;
		return sum[16:0];
	endfunction

endpackage

// ===== rtl/core/fvr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fire-voltage regulator controller
// Steps each accepted item through load, two multiply steps and a final
// write into the output register, and keeps the output valid flag.
// ----------------------------------------------------------------------------
module fvr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	output fvr_pkg::fvr_cmd_t cmd
);
	import fvr_pkg::*;

	fvr_state_t state_q;
	fvr_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_FIN;
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath and handshake outputs.
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_FIN:  cmd.fin  = slot_free;
			default: cmd = '0;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/fvr_dp.sv =====
// ----------------------------------------------------------------------------
// Fire-voltage regulator datapath
// Filter, trim and setpoint state with one shared multiplier, driven step
// by step by the controller, and the result register.
// ----------------------------------------------------------------------------
module fvr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  fvr_pkg::fvr_cmd_t cmd,
	input  fvr_pkg::fvr_in_t  in_data,
	input  logic [8:0]        target,
	output fvr_pkg::fvr_out_t out_data
);
	import fvr_pkg::*;

	// Regulator state.
	logic signed [16:0] fire_f_q;
	logic signed [16:0] motor_f_q;
	logic [9:0]         trim_q;
	logic [15:0]        tf_q;
	logic [9:0]         fire_now_q;
	logic [6:0]         motor_now_q;
	logic [15:0]        last_dac_q;

	// Working registers for the item in flight.
	logic               mode_q;
	logic [1:0]         ch_q;
	logic [13:0]        v1_q;
	logic [10:0]        k_q;
	logic [29:0]        prod_q;
	fvr_out_t           out_q;

	logic [1:0]         in_ch;
	logic [11:0]        in_sample;
	logic [16:0]        tf_rnd;
	logic [15:0]        tf_new;
	logic [16:0]        tf_new_rnd;
	logic [13:0]        gain_sum;
	logic [30:0]        prod_rnd_now;
	logic [30:0]        prod_rnd_v;
	logic [9:0]         fire_new;
	logic [6:0]         motor_new;
	logic [13:0]        v_raw;
	logic [8:0]         v_sat;
	logic [16:0]        mul_a;
	logic [21:0]        mul_b;
	logic [38:0]        mul_p;
	logic [15:0]        dac_next;

	assign in_ch     = in_data.adc_word[13:12];
	assign in_sample = in_data.adc_word[11:0];

	// Target smoothing and gain for a setpoint request.
	assign tf_rnd     = {1'b0, tf_q} + 17'd4;
	assign tf_new     = 16'(tf_q + {7'b0, target} - {2'b0, tf_rnd[16:3]});
	assign tf_new_rnd = {1'b0, tf_new} + 17'd4;
	assign gain_sum   = GAIN_BASE + {4'b0, trim_q};

	// Rounding of the registered product.
	assign prod_rnd_now = {1'b0, prod_q} + 31'd32768;
	assign prod_rnd_v   = {1'b0, prod_q} + 31'd128;
	assign fire_new     = prod_rnd_now[25:16];
	assign motor_new    = prod_rnd_now[22:16];
	assign v_raw        = prod_rnd_v[23:10];
	assign v_sat        = (v_raw > {5'b0, VOLT_LIMIT}) ? VOLT_LIMIT : v_raw[8:0];

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul1) begin
			if (mode_q) begin
				mul_a = {3'b0, v1_q};
				mul_b = {11'b0, k_q};
			end else if (ch_q == CH_FIRE) begin
				mul_a = fire_f_q;
				mul_b = FIRE_SCALE;
			end else begin
				mul_a = motor_f_q;
				mul_b = MOTOR_SCALE;
			end
		end else begin
			mul_a = {8'b0, v_sat};
			mul_b = DAC_SCALE;
		end
	end

	assign mul_p = {22'b0, mul_a} * {17'b0, mul_b};

	assign dac_next = mode_q ? ~prod_q[29:14] : last_dac_q;

	// Control-side state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_f_q    <= '0;
			motor_f_q   <= '0;
			trim_q      <= TRIM_RESET;
			tf_q        <= '0;
			fire_now_q  <= '0;
			motor_now_q <= '0;
			last_dac_q  <= '0;
		end else begin
			// Filter or target update when the item is taken.
			if (cmd.load) begin
				if (in_data.mode) begin
					tf_q <= tf_new;
				end else if (in_ch == CH_FIRE) begin
					fire_f_q <= fvr_filt_step(fire_f_q, in_sample);
				end else if (in_ch == CH_MOTOR) begin
					motor_f_q <= fvr_filt_step(motor_f_q, in_sample);
				end
			end
			// Voltage readout and trim step for ADC words.
			if (cmd.mul2 && !mode_q) begin
				if (ch_q == CH_FIRE) begin
					fire_now_q <= fire_new;
					if ({1'b0, target} > fire_new) begin
						if (trim_q != TRIM_MAX) begin
							trim_q <= trim_q + 10'd1;
						end
					end else if ({1'b0, target} < fire_new) begin
						if (trim_q != '0) begin
							trim_q <= trim_q - 10'd1;
						end
					end
				end else if (ch_q == CH_MOTOR) begin
					motor_now_q <= motor_new;
				end
			end
			if (cmd.fin) begin
				last_dac_q <= dac_next;
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_data.mode;
			ch_q   <= in_ch;
			v1_q   <= tf_new_rnd[16:3] + 14'd10;
			k_q    <= gain_sum[13:3];
		end
		if (cmd.mul1 || (cmd.mul2 && mode_q)) begin
			prod_q <= mul_p[29:0];
		end
		if (cmd.fin) begin
			out_q.fire_voltage  <= fire_now_q;
			out_q.motor_voltage <= motor_now_q;
			out_q.trim          <= trim_q;
			out_q.dac_code      <= dac_next;
			out_q.dac_valid     <= mode_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== rtl/core/fire_voltage_regulator_core.sv =====
// ----------------------------------------------------------------------------
// Fire-voltage regulator core: ADC filtering, trim tracking, DAC setpoint.
// An item is taken only when idle, after the last one is through; MUL1, MUL2
// and FIN follow, paced by the shared multiplier in the datapath sequence.
// Asynchronous reset sets target 250, trim 512 and zero filters.
// ----------------------------------------------------------------------------
module fire_voltage_regulator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  fvr_pkg::fvr_in_t                       in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output fvr_pkg::fvr_out_t                      out_data,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [fvr_pkg::CFG_ADDR_W-1:0]         paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import fvr_pkg::*;

	fvr_cmd_t   cmd;
	logic [8:0] target_q;
	logic       cfg_wr;
	logic       target_hit;

	// Register write on the access phase of a transfer.
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign target_hit = (paddr[2] == CFG_IDX_TARGET) && (paddr[1:0] == 2'b00);

	// Target register; values above the voltage limit are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_wr && target_hit && (pwdata[8:0] <= VOLT_LIMIT)) begin
			target_q <= pwdata[8:0];
		end
	end

	// Register read-back.
	assign prdata = target_hit ? {23'b0, target_q} : 32'b0;

	fvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	fvr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.target   (target_q),
		.out_data (out_data)
	);

endmodule
